// File: hdl/tcc_pkg.sv
// Shared types and constants of the tick calendar and countdown timers unit.
`timescale 1ns / 1ps

package tcc_pkg;

  // Item opcodes. The remaining code is ignored by the block.
  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_LOAD_TIMER = 2'd1,
    OP_SET_FIELD  = 2'd2
  } opcode_t;

  // Calendar fields selected by a set-field item.
  typedef enum logic [2:0] {
    FLD_CS    = 3'd0,
    FLD_SEC   = 3'd1,
    FLD_MIN   = 3'd2,
    FLD_HOUR  = 3'd3,
    FLD_DAY   = 3'd4,
    FLD_MONTH = 3'd5,
    FLD_YEAR  = 3'd6
  } cal_field_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SAMPLE_PERIOD   = 2'd0,
    REG_WATCHDOG_RELOAD = 2'd1,
    REG_BLINK_RELOAD    = 2'd2,
    REG_WATCHDOG_ENABLE = 2'd3
  } cfg_reg_t;

  // Input item: a tick or a write.
  typedef struct packed {
    opcode_t     opcode;
    logic [2:0]  target;
    logic [15:0] load_value;
    logic        sub_alive;
  } in_item_t;

  // Result item: state after the step plus per-tick flags.
  typedef struct packed {
    logic [6:0]  centisec;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day_of_month;
    logic [3:0]  month_num;
    logic [15:0] year_count;
    logic        sample_pulse;
    logic        tms_expired;
    logic        watchdog_halt;
    logic [6:0]  timers_busy;
    logic        blink_reloaded;
  } out_item_t;

  // Configuration write.
  typedef struct packed {
    cfg_reg_t    index;
    logic [15:0] value;
  } cfg_item_t;

  // Rollover limits, one bit wider than the unit so the carry-in sum fits.
  localparam logic [7:0] CS_LIMIT    = 8'd99;
  localparam logic [6:0] SEC_LIMIT   = 7'd59;
  localparam logic [6:0] MIN_LIMIT   = 7'd59;
  localparam logic [5:0] HOUR_LIMIT  = 6'd23;
  localparam logic [4:0] MONTH_LIMIT = 5'd12;

  // Day limits per month.
  localparam logic [5:0] DAYS_LEAP_FEB = 6'd29;
  localparam logic [5:0] DAYS_FEB      = 6'd28;
  localparam logic [5:0] DAYS_SHORT    = 6'd30;
  localparam logic [5:0] DAYS_LONG     = 6'd31;

  // Month numbers with special day limits.
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;

  // Configuration reset values.
  localparam logic [7:0]  SAMPLE_PERIOD_RST   = 8'd4;
  localparam logic [15:0] WATCHDOG_RELOAD_RST = 16'd1000;
  localparam logic [15:0] BLINK_RELOAD_RST    = 16'd50;

  // Timer with the expiry flag, and number of busy bits reported.
  localparam int TMS_INDEX = 1;
  localparam int BUSY_W    = 7;

endpackage

// File: hdl/tcc_stream_if.sv
// Valid/ready channel interface carrying one payload item per handshake.
`timescale 1ns / 1ps

interface tcc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/tick_calendar_and_countdown_timers_unit.sv
// Top level: tick calendar, countdown timers, blink counter and watchdog.
//
// Usage: every 10 ms tick or write enters as one item on in_ch (opcode,
// target, load_value, sub_alive). Each item yields exactly one result item
// on out_ch with the calendar after the step and the per-tick flags.
// Configuration registers are written on cfg_ch (always ready); the user
// must write them only while the block is idle, and the block itself does
// not enforce this. An accepted item sits in the input register, and its
// result is loaded into the output register. Throughput is one item per
// cycle while out_ch does not stall, set by the combinational update of
// the calendar cascade and timer decrements feeding back into the state
// registers.
// An empty input register still takes an item while a finished result waits
// in the output register; when out_ch stalls, both registers fill and in_ch
// ready drops until the receiver takes the result.
// Reset (rst_n low, synchronous) sets the calendar to day 1, month 1,
// year 0, clears all timers and the watchdog halt, and loads the
// configuration defaults. Once the watchdog halts the block, ticks and
// writes leave the state unchanged until reset.
`timescale 1ns / 1ps

module tick_calendar_and_countdown_timers_unit #(
  parameter int NUM_TIMERS  = 7,
  parameter int TIMER_WIDTH = 16
) (
  input logic          clk,
  input logic          rst_n,
  tcc_stream_if.sink   in_ch,
  tcc_stream_if.source out_ch,
  tcc_stream_if.sink   cfg_ch
);

  // Configuration registers.
  logic [7:0]  sample_period_r;
  logic [15:0] watchdog_reload_r;
  logic [15:0] blink_reload_r;
  logic        watchdog_enable_r;

  // Input and output registers.
  logic                 s1_valid_r;
  tcc_pkg::in_item_t    s1_item_r;
  logic                 out_valid_r;
  tcc_pkg::out_item_t   out_item_r;
  tcc_pkg::out_item_t   result;

  // Block state.
  logic [6:0]             cs_r, cs_nxt;
  logic [5:0]             sec_r, sec_nxt;
  logic [5:0]             min_r, min_nxt;
  logic [4:0]             hour_r, hour_nxt;
  logic [4:0]             day_r, day_nxt;
  logic [3:0]             month_r, month_nxt;
  logic [15:0]            year_r, year_nxt;
  logic [7:0]             sample_count_r, sample_count_nxt;
  logic [TIMER_WIDTH-1:0] cd_r [NUM_TIMERS];
  logic [TIMER_WIDTH-1:0] cd_nxt [NUM_TIMERS];
  logic [15:0]            wd_count_r, wd_count_nxt;
  logic [15:0]            blink_r, blink_nxt;
  logic                   halted_r, halted_nxt;

  // Handshake control.
  logic s2_go;
  logic in_take;

  // Combinational work signals.
  logic [TIMER_WIDTH-1:0] load_ext;
  logic [8:0]  sc_inc;
  logic [7:0]  cs_sum;
  logic [6:0]  sec_sum;
  logic [6:0]  min_sum;
  logic [5:0]  hour_sum;
  logic [5:0]  day_sum;
  logic [4:0]  month_sum;
  logic [3:0]  month_fix;
  logic [5:0]  day_limit;
  logic        cs_carry, sec_carry, min_carry, hour_carry;
  logic [15:0] wd_dec;
  logic        halt_now;
  logic        pulse, tms, blinked;
  logic [6:0]  busy;

  assign s2_go        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s2_go;
  assign in_take      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;
  assign load_ext     = TIMER_WIDTH'(32'(s1_item_r.load_value));

  // Next state and result for the item in the input register.
  always_comb begin
    cs_nxt           = cs_r;
    sec_nxt          = sec_r;
    min_nxt          = min_r;
    hour_nxt         = hour_r;
    day_nxt          = day_r;
    month_nxt        = month_r;
    year_nxt         = year_r;
    sample_count_nxt = sample_count_r;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      cd_nxt[i] = cd_r[i];
    end
    wd_count_nxt = wd_count_r;
    blink_nxt    = blink_r;
    halted_nxt   = halted_r;
    pulse        = 1'b0;
    tms          = 1'b0;
    blinked      = 1'b0;
    halt_now     = 1'b0;

    // Sample pulse counter at full precision.
    sc_inc = {1'b0, sample_count_r} + 9'd1;

    // Calendar cascade: centiseconds up to hours.
    cs_sum     = {1'b0, cs_r} + 8'd1;
    cs_carry   = cs_sum > tcc_pkg::CS_LIMIT;
    sec_sum    = {1'b0, sec_r} + {6'd0, cs_carry};
    sec_carry  = sec_sum > tcc_pkg::SEC_LIMIT;
    min_sum    = {1'b0, min_r} + {6'd0, sec_carry};
    min_carry  = min_sum > tcc_pkg::MIN_LIMIT;
    hour_sum   = {1'b0, hour_r} + {5'd0, min_carry};
    hour_carry = hour_sum > tcc_pkg::HOUR_LIMIT;

    // Day and month, with zero forced to one.
    day_sum = {1'b0, day_r} + {5'd0, hour_carry};
    if (day_sum == 6'd0) begin
      day_sum = 6'd1;
    end
    month_fix = (month_r == 4'd0) ? 4'd1 : month_r;
    if (month_fix == tcc_pkg::MONTH_FEB) begin
      day_limit = (year_r[1:0] == 2'd0) ? tcc_pkg::DAYS_LEAP_FEB : tcc_pkg::DAYS_FEB;
    end else if (month_fix inside {tcc_pkg::MONTH_APR, tcc_pkg::MONTH_JUN,
                                   tcc_pkg::MONTH_SEP, tcc_pkg::MONTH_NOV}) begin
      day_limit = tcc_pkg::DAYS_SHORT;
    end else begin
      day_limit = tcc_pkg::DAYS_LONG;
    end
    month_sum = {1'b0, month_fix};
    if (day_sum > day_limit) begin
      day_sum   = 6'd1;
      month_sum = month_sum + 5'd1;
    end

    // Watchdog count after its decrement.
    wd_dec = (wd_count_r != 16'd0) ? wd_count_r - 16'd1 : wd_count_r;

    if (s1_valid_r && !halted_r) begin
      case (s1_item_r.opcode)
        tcc_pkg::OP_LOAD_TIMER: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (int'(s1_item_r.target) == i) begin
              cd_nxt[i] = load_ext;
            end
          end
        end
        tcc_pkg::OP_SET_FIELD: begin
          case (tcc_pkg::cal_field_t'(s1_item_r.target))
            tcc_pkg::FLD_CS:    cs_nxt    = s1_item_r.load_value[6:0];
            tcc_pkg::FLD_SEC:   sec_nxt   = s1_item_r.load_value[5:0];
            tcc_pkg::FLD_MIN:   min_nxt   = s1_item_r.load_value[5:0];
            tcc_pkg::FLD_HOUR:  hour_nxt  = s1_item_r.load_value[4:0];
            tcc_pkg::FLD_DAY:   day_nxt   = s1_item_r.load_value[4:0];
            tcc_pkg::FLD_MONTH: month_nxt = s1_item_r.load_value[3:0];
            tcc_pkg::FLD_YEAR:  year_nxt  = s1_item_r.load_value;
            default: ;
          endcase
        end
        tcc_pkg::OP_TICK: begin
          // Sample pulse.
          if (sc_inc > {1'b0, sample_period_r}) begin
            sample_count_nxt = 8'd0;
            pulse            = 1'b1;
          end else begin
            sample_count_nxt = sc_inc[7:0];
          end

          // Calendar update.
          cs_nxt   = cs_carry ? 7'd0 : cs_sum[6:0];
          sec_nxt  = sec_carry ? 6'd0 : sec_sum[5:0];
          min_nxt  = min_carry ? 6'd0 : min_sum[5:0];
          hour_nxt = hour_carry ? 5'd0 : hour_sum[4:0];
          day_nxt  = day_sum[4:0];
          if (month_sum > tcc_pkg::MONTH_LIMIT) begin
            month_nxt = 4'd1;
            year_nxt  = year_r + 16'd1;
          end else begin
            month_nxt = month_sum[3:0];
          end

          // Watchdog: a missing heartbeat at zero halts the block.
          if (watchdog_enable_r) begin
            if (s1_item_r.sub_alive) begin
              wd_count_nxt = watchdog_reload_r;
            end else begin
              wd_count_nxt = wd_dec;
              halt_now     = (wd_dec == 16'd0);
            end
          end else begin
            wd_count_nxt = watchdog_reload_r;
          end
          halted_nxt = halt_now;

          // Countdown timers; the last one stops when the block halts.
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (cd_r[i] != '0 && (i != NUM_TIMERS - 1 || !halt_now)) begin
              cd_nxt[i] = cd_r[i] - TIMER_WIDTH'(1);
              if (i == tcc_pkg::TMS_INDEX && cd_r[i] == TIMER_WIDTH'(1)) begin
                tms = 1'b1;
              end
            end
          end

          // Blink counter reloads at zero.
          if (!halt_now) begin
            if (blink_r != 16'd0) begin
              blink_nxt = blink_r - 16'd1;
            end else begin
              blink_nxt = blink_reload_r;
              blinked   = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // Busy bits for the first timers.
    busy = 7'd0;
    for (int i = 0; i < tcc_pkg::BUSY_W && i < NUM_TIMERS; i++) begin
      busy[i] = (cd_nxt[i] != '0);
    end

    result.centisec       = cs_nxt;
    result.seconds        = sec_nxt;
    result.minutes        = min_nxt;
    result.hours          = hour_nxt;
    result.day_of_month   = day_nxt;
    result.month_num      = month_nxt;
    result.year_count     = year_nxt;
    result.sample_pulse   = pulse;
    result.tms_expired    = tms;
    result.watchdog_halt  = halted_nxt;
    result.timers_busy    = busy;
    result.blink_reloaded = blinked;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r   <= tcc_pkg::SAMPLE_PERIOD_RST;
      watchdog_reload_r <= tcc_pkg::WATCHDOG_RELOAD_RST;
      blink_reload_r    <= tcc_pkg::BLINK_RELOAD_RST;
      watchdog_enable_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        tcc_pkg::REG_SAMPLE_PERIOD:   sample_period_r   <= cfg_ch.data.value[7:0];
        tcc_pkg::REG_WATCHDOG_RELOAD: watchdog_reload_r <= cfg_ch.data.value;
        tcc_pkg::REG_BLINK_RELOAD:    blink_reload_r    <= cfg_ch.data.value;
        tcc_pkg::REG_WATCHDOG_ENABLE: watchdog_enable_r <= cfg_ch.data.value[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s2_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_ch.data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_item_r <= result;
    end
  end

  // State registers, updated once per processed item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r           <= 7'd0;
      sec_r          <= 6'd0;
      min_r          <= 6'd0;
      hour_r         <= 5'd0;
      day_r          <= 5'd1;
      month_r        <= 4'd1;
      year_r         <= 16'd0;
      sample_count_r <= 8'd0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cd_r[i] <= '0;
      end
      wd_count_r <= 16'd0;
      blink_r    <= 16'd0;
      halted_r   <= 1'b0;
    end else if (s2_go) begin
      cs_r           <= cs_nxt;
      sec_r          <= sec_nxt;
      min_r          <= min_nxt;
      hour_r         <= hour_nxt;
      day_r          <= day_nxt;
      month_r        <= month_nxt;
      year_r         <= year_nxt;
      sample_count_r <= sample_count_nxt;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cd_r[i] <= cd_nxt[i];
      end
      wd_count_r <= wd_count_nxt;
      blink_r    <= blink_nxt;
      halted_r   <= halted_nxt;
    end
  end

endmodule

// File: tb/tb.sv
// Self-checking testbench for the tick calendar and countdown timers unit.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_TIMERS    = 7;
  localparam int TIMER_WIDTH   = 16;
  localparam int LAST_TIMER    = NUM_TIMERS - 1;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int YEAR_WRAP     = 65536;

  // Opcode that the block ignores, and a target that no timer or field uses.
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [2:0] BAD_TARGET = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  tcc_stream_if #(.payload_t(tcc_pkg::in_item_t))  in_ch ();
  tcc_stream_if #(.payload_t(tcc_pkg::out_item_t)) out_ch ();
  tcc_stream_if #(.payload_t(tcc_pkg::cfg_item_t)) cfg_ch ();

  tick_calendar_and_countdown_timers_unit #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIMER_WIDTH(TIMER_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #5 clk = ~clk;

  // Predicted register settings.
  int cfg_sample_period;
  int cfg_watchdog_reload;
  int cfg_blink_reload;
  int cfg_watchdog_enable;

  // Predicted calendar, timers and watchdog state.
  int cal_cs, cal_sec, cal_min, cal_hour, cal_day, cal_month, cal_year;
  int sample_cnt;
  int countdown[NUM_TIMERS];
  int wdog_cnt;
  int blink_cnt;
  bit wdog_halted;

  tcc_pkg::out_item_t expected_readings[$];
  tcc_pkg::out_item_t oldest_reading;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;

  // One calendar unit: add the carry, wrap to zero past the limit.
  task automatic roll_unit(inout int unit, inout int carry, input int limit);
    int sum;
    sum = unit + carry;
    if (sum > limit) begin
      unit  = 0;
      carry = 1;
    end else begin
      unit  = sum;
      carry = 0;
    end
  endtask

  // Apply one item to the predicted state and form the reading it produces.
  task automatic advance_clock_state(input tcc_pkg::in_item_t item,
                                     output tcc_pkg::out_item_t res);
    int         carry;
    int         day_limit;
    bit         pulse;
    bit         tms;
    bit         blinked;
    logic [6:0] busy;
    pulse   = 1'b0;
    tms     = 1'b0;
    blinked = 1'b0;
    if (!wdog_halted) begin
      case (item.opcode)
        tcc_pkg::OP_LOAD_TIMER: begin
          if (int'(item.target) < NUM_TIMERS) begin
            countdown[item.target] = int'(item.load_value);
          end
        end
        tcc_pkg::OP_SET_FIELD: begin
          case (tcc_pkg::cal_field_t'(item.target))
            tcc_pkg::FLD_CS:    cal_cs    = int'(item.load_value[6:0]);
            tcc_pkg::FLD_SEC:   cal_sec   = int'(item.load_value[5:0]);
            tcc_pkg::FLD_MIN:   cal_min   = int'(item.load_value[5:0]);
            tcc_pkg::FLD_HOUR:  cal_hour  = int'(item.load_value[4:0]);
            tcc_pkg::FLD_DAY:   cal_day   = int'(item.load_value[4:0]);
            tcc_pkg::FLD_MONTH: cal_month = int'(item.load_value[3:0]);
            tcc_pkg::FLD_YEAR:  cal_year  = int'(item.load_value);
            default: ;
          endcase
        end
        tcc_pkg::OP_TICK: begin
          sample_cnt++;
          if (sample_cnt > cfg_sample_period) begin
            sample_cnt = 0;
            pulse      = 1'b1;
          end
          // Calendar cascade at full precision, then the day and month limits.
          carry = 1;
          roll_unit(cal_cs, carry, int'(tcc_pkg::CS_LIMIT));
          roll_unit(cal_sec, carry, int'(tcc_pkg::SEC_LIMIT));
          roll_unit(cal_min, carry, int'(tcc_pkg::MIN_LIMIT));
          roll_unit(cal_hour, carry, int'(tcc_pkg::HOUR_LIMIT));
          cal_day += carry;
          if (cal_day == 0) cal_day = 1;
          if (cal_month == 0) cal_month = 1;
          if (cal_month == int'(tcc_pkg::MONTH_FEB)) begin
            day_limit = (cal_year % 4 == 0) ? int'(tcc_pkg::DAYS_LEAP_FEB)
                                            : int'(tcc_pkg::DAYS_FEB);
          end else if (cal_month == int'(tcc_pkg::MONTH_APR) ||
                       cal_month == int'(tcc_pkg::MONTH_JUN) ||
                       cal_month == int'(tcc_pkg::MONTH_SEP) ||
                       cal_month == int'(tcc_pkg::MONTH_NOV)) begin
            day_limit = int'(tcc_pkg::DAYS_SHORT);
          end else begin
            day_limit = int'(tcc_pkg::DAYS_LONG);
          end
          if (cal_day > day_limit) begin
            cal_day = 1;
            cal_month++;
          end
          if (cal_month > int'(tcc_pkg::MONTH_LIMIT)) begin
            cal_month = 1;
            cal_year  = (cal_year + 1) % YEAR_WRAP;
          end
          // All timers but the last count down before the watchdog check.
          for (int i = 0; i < LAST_TIMER; i++) begin
            if (countdown[i] != 0) begin
              countdown[i]--;
              if (i == tcc_pkg::TMS_INDEX && countdown[i] == 0) tms = 1'b1;
            end
          end
          if (wdog_cnt != 0) wdog_cnt--;
          if (cfg_watchdog_enable != 0) begin
            if (item.sub_alive) wdog_cnt = cfg_watchdog_reload;
            else if (wdog_cnt == 0) wdog_halted = 1'b1;
          end else begin
            wdog_cnt = cfg_watchdog_reload;
          end
          // The blink counter and the last timer stop on the halting tick.
          if (!wdog_halted) begin
            if (blink_cnt != 0) begin
              blink_cnt--;
            end else begin
              blink_cnt = cfg_blink_reload;
              blinked   = 1'b1;
            end
            if (countdown[LAST_TIMER] != 0) countdown[LAST_TIMER]--;
          end
        end
        default: ;
      endcase
    end
    for (int i = 0; i < tcc_pkg::BUSY_W; i++) busy[i] = (countdown[i] != 0);
    res.centisec       = cal_cs[6:0];
    res.seconds        = cal_sec[5:0];
    res.minutes        = cal_min[5:0];
    res.hours          = cal_hour[4:0];
    res.day_of_month   = cal_day[4:0];
    res.month_num      = cal_month[3:0];
    res.year_count     = cal_year[15:0];
    res.sample_pulse   = pulse;
    res.tms_expired    = tms;
    res.watchdog_halt  = wdog_halted;
    res.timers_busy    = busy;
    res.blink_reloaded = blinked;
  endtask

  // Offer one item after an optional random gap and predict its reading.
  task automatic send_item(input logic [1:0] op, input logic [2:0] tgt,
                           input logic [15:0] val, input logic alive);
    tcc_pkg::in_item_t  item;
    tcc_pkg::out_item_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item.opcode     = tcc_pkg::opcode_t'(op);
    item.target     = tgt;
    item.load_value = val;
    item.sub_alive  = alive;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_clock_state(item, res);
    expected_readings.push_back(res);
  endtask

  // Hold off the sender until every predicted reading has come back.
  task automatic wait_for_all_results();
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid stays up for a following write.
  task automatic write_register(input tcc_pkg::cfg_reg_t idx, input logic [15:0] val);
    tcc_pkg::cfg_item_t wr;
    wr.index = idx;
    wr.value = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= wr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      tcc_pkg::REG_SAMPLE_PERIOD:   cfg_sample_period   = int'(val[7:0]);
      tcc_pkg::REG_WATCHDOG_RELOAD: cfg_watchdog_reload = int'(val);
      tcc_pkg::REG_BLINK_RELOAD:    cfg_blink_reload    = int'(val);
      tcc_pkg::REG_WATCHDOG_ENABLE: cfg_watchdog_enable = int'(val[0]);
      default: ;
    endcase
  endtask

  // Write all four registers; only called while the block is idle.
  task automatic apply_settings(input int period, input int wd_reload,
                                input int blink, input int wd_on);
    write_register(tcc_pkg::REG_SAMPLE_PERIOD, period[15:0]);
    write_register(tcc_pkg::REG_WATCHDOG_RELOAD, wd_reload[15:0]);
    write_register(tcc_pkg::REG_BLINK_RELOAD, blink[15:0]);
    write_register(tcc_pkg::REG_WATCHDOG_ENABLE, wd_on[15:0]);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random item: mostly ticks, timer loads and calendar writes near limits.
  task automatic send_random_item(input bit wd_on);
    int          pick;
    logic [2:0]  tgt;
    logic [15:0] val;
    pick = $urandom_range(99);
    tgt  = 3'($urandom_range(7));
    val  = 16'($urandom_range(65535));
    if (pick < 55) begin
      send_item(tcc_pkg::OP_TICK, tgt, val,
                wd_on ? ($urandom_range(3) != 0) : 1'($urandom_range(1)));
    end else if (pick < 72) begin
      if ($urandom_range(3) != 0) val = 16'($urandom_range(30));
      send_item(tcc_pkg::OP_LOAD_TIMER, tgt, val, 1'($urandom_range(1)));
    end else if (pick < 94) begin
      if ($urandom_range(4) != 0) begin
        case (tcc_pkg::cal_field_t'(tgt))
          tcc_pkg::FLD_CS:    val = 16'($urandom_range(99, 90));
          tcc_pkg::FLD_SEC:   val = 16'($urandom_range(59, 55));
          tcc_pkg::FLD_MIN:   val = 16'($urandom_range(59, 55));
          tcc_pkg::FLD_HOUR:  val = 16'($urandom_range(23, 20));
          tcc_pkg::FLD_DAY:   val = 16'($urandom_range(31));
          tcc_pkg::FLD_MONTH: val = 16'($urandom_range(12));
          default: ;
        endcase
      end
      send_item(tcc_pkg::OP_SET_FIELD, tgt, val, 1'($urandom_range(1)));
    end else begin
      send_item(OP_IGNORED, tgt, val, 1'($urandom_range(1)));
    end
  endtask

  // Rollovers of every calendar unit, month lengths and forced fields.
  task automatic test_calendar_edges();
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_CS, 16'd99, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_SEC, 16'd59, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_MIN, 16'd59, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_HOUR, 16'd23, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_DAY, 16'd31, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_MONTH, 16'd12, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_YEAR, 16'hFFFF, 1'b1);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
    // Day 29 in a common-year February rolls over; in a leap year it holds.
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_MONTH, 16'd2, 1'b0);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_DAY, 16'd29, 1'b0);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_YEAR, 16'd1, 1'b0);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b0);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_MONTH, 16'd2, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_DAY, 16'd29, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_YEAR, 16'd4, 1'b1);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
    // A zero day and month are forced to one.
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_DAY, 16'd0, 1'b0);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_MONTH, 16'd0, 1'b0);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b0);
    // Out-of-range writes are masked, then normalized by the next tick.
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_CS, 16'hFFFF, 1'b1);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_HOUR, 16'd31, 1'b1);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
  endtask

  // Timer expiry, busy bits and items that the block must ignore.
  task automatic test_timers_and_ignored_items();
    send_item(tcc_pkg::OP_LOAD_TIMER, BAD_TARGET, 16'd5, 1'b0);
    send_item(tcc_pkg::OP_SET_FIELD, BAD_TARGET, 16'd5, 1'b0);
    send_item(OP_IGNORED, 3'd2, 16'hA5A5, 1'b1);
    send_item(tcc_pkg::OP_LOAD_TIMER, 3'(tcc_pkg::TMS_INDEX), 16'd1, 1'b1);
    send_item(tcc_pkg::OP_LOAD_TIMER, 3'(LAST_TIMER), 16'hFFFF, 1'b1);
    send_item(tcc_pkg::OP_LOAD_TIMER, 3'd0, 16'd2, 1'b1);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
  endtask

  // Sample period extremes: every tick, and once every 256 ticks.
  task automatic test_sample_period_limits();
    wait_for_all_results();
    apply_settings(0, 0, 0, 0);
    repeat (4) send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b0);
    wait_for_all_results();
    apply_settings(255, 65535, 65535, 0);
    repeat (258) send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
  endtask

  // Random traffic under each idling pattern, with fresh settings per phase.
  task automatic test_random_traffic();
    int idle_pct[4];
    int stall_pct[4];
    int wd_on;
    idle_pct  = '{0, 77, 0, 25};
    stall_pct = '{0, 0, 77, 25};
    for (int ph = 0; ph < 4; ph++) begin
      wait_for_all_results();
      send_idle_pct  = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      wd_on = $urandom_range(1);
      apply_settings($urandom_range(12), wd_on ? $urandom_range(65535, 2000)
                                               : $urandom_range(65535),
                     $urandom_range(20), wd_on);
      // A heartbeat first, so the watchdog starts from a full reload.
      if (wd_on != 0) send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
      repeat (60) begin
        send_random_item(wd_on != 0);
        if ($urandom_range(49) == 0) wait_for_all_results();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Missed heartbeats halt the block; nothing changes afterwards.
  task automatic test_watchdog_halt();
    wait_for_all_results();
    apply_settings(3, 3, 0, 1);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
    repeat (3) send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b0);
    send_item(tcc_pkg::OP_SET_FIELD, tcc_pkg::FLD_MIN, 16'd30, 1'b1);
    send_item(tcc_pkg::OP_LOAD_TIMER, 3'd3, 16'd9, 1'b1);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
    send_item(OP_IGNORED, 3'd0, 16'd0, 1'b0);
    wait_for_all_results();
    apply_settings(0, 65535, 65535, 0);
    send_item(tcc_pkg::OP_TICK, 3'd0, 16'd0, 1'b1);
  endtask

  function automatic void check_field(input string name, input logic [15:0] expv,
                                      input logic [15:0] gotv);
    if (gotv !== expv) begin
      $error("%s: expected %0d, got %0d", name, expv, gotv);
      mismatches++;
    end
  endfunction

  // Receiver: random stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each accepted reading with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $error("reading received with no item outstanding");
        mismatches++;
      end else begin
        oldest_reading = expected_readings.pop_front();
        check_field("centisec", 16'(oldest_reading.centisec),
                    16'(out_ch.data.centisec));
        check_field("seconds", 16'(oldest_reading.seconds),
                    16'(out_ch.data.seconds));
        check_field("minutes", 16'(oldest_reading.minutes),
                    16'(out_ch.data.minutes));
        check_field("hours", 16'(oldest_reading.hours),
                    16'(out_ch.data.hours));
        check_field("day_of_month", 16'(oldest_reading.day_of_month),
                    16'(out_ch.data.day_of_month));
        check_field("month_num", 16'(oldest_reading.month_num),
                    16'(out_ch.data.month_num));
        check_field("year_count", oldest_reading.year_count, out_ch.data.year_count);
        check_field("sample_pulse", 16'(oldest_reading.sample_pulse),
                    16'(out_ch.data.sample_pulse));
        check_field("tms_expired", 16'(oldest_reading.tms_expired),
                    16'(out_ch.data.tms_expired));
        check_field("watchdog_halt", 16'(oldest_reading.watchdog_halt),
                    16'(out_ch.data.watchdog_halt));
        check_field("timers_busy", 16'(oldest_reading.timers_busy),
                    16'(out_ch.data.timers_busy));
        check_field("blink_reloaded", 16'(oldest_reading.blink_reloaded),
                    16'(out_ch.data.blink_reloaded));
      end
    end
  end

  // Stall watchdog: too long without any handshake ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Reset, predicted reset state, then the tests in turn.
  initial begin
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    cfg_sample_period   = int'(tcc_pkg::SAMPLE_PERIOD_RST);
    cfg_watchdog_reload = int'(tcc_pkg::WATCHDOG_RELOAD_RST);
    cfg_blink_reload    = int'(tcc_pkg::BLINK_RELOAD_RST);
    cfg_watchdog_enable = 0;
    cal_cs      = 0;
    cal_sec     = 0;
    cal_min     = 0;
    cal_hour    = 0;
    cal_day     = 1;
    cal_month   = 1;
    cal_year    = 0;
    sample_cnt  = 0;
    wdog_cnt    = 0;
    blink_cnt   = 0;
    wdog_halted = 1'b0;
    foreach (countdown[i]) countdown[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_calendar_edges();
    test_timers_and_ignored_items();
    test_sample_period_limits();
    test_random_traffic();
    test_watchdog_halt();

    wait_for_all_results();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
